### rtl/core/rfcc_pkg.sv
// Package: shared types, constants and the byte-wide CRC-16 step for the frame checker.
package rfcc_pkg;

  localparam int unsigned MAX_FRAME_LIMIT = 155;
  localparam int unsigned MIN_FRAME_LEN   = 4;
  localparam logic [15:0] CRC_POLY        = 16'h8005;
  localparam logic [7:0]  STATUS_OK       = 8'h00;
  localparam logic [7:0]  MAX_LEN_RESET   = 8'd155;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_MAX_FRAME_LEN = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_BAD_LEN = 2'd1,
    VERDICT_CRC_ERR = 2'd2,
    VERDICT_DEV_ERR = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  status_code;
    logic [7:0]  frame_length;
    logic [15:0] crc_computed;
  } result_t;

  // One byte through the CRC, data LSB first, MSB-first register shift.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = c[15] ^ data[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/response_frame_crc_checker_core.sv
// Top level: input register, frame checker, result register and config port.
// Checks length-prefixed response frames one byte per transaction. A byte
// with in_frame_start high is the frame's count byte; a count below 4, above
// max_frame_len or above 155 gives a bad-length result at once. Otherwise a
// CRC-16 (poly 0x8005, init 0, data LSB first, no output reflection) runs
// over all but the last two bytes, which hold the expected CRC low byte
// first, and the last byte yields one result: ok, CRC mismatch, or device
// error (4-byte frame with nonzero status). Bytes outside a frame
// produce nothing; a new start inside a frame drops the open one silently.
// Throughput is one byte per cycle unless out_stall holds a result: the
// unrolled CRC step follows the input register. The last byte passes the
// input and result registers before out_valid; the one-entry input register
// takes a byte while a result waits. The user must write max_frame_len
// (byte address 0, reset 155) only while idle; the block does not check it.
module response_frame_crc_checker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             in_frame_start,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_verdict,
  output logic [7:0]                       out_status_code,
  output logic [7:0]                       out_frame_length,
  output logic [15:0]                      out_crc_computed,
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rfcc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rfcc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rfcc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import rfcc_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  logic       in_accept;
  logic       out_free;
  logic       fire;
  logic       emit;
  result_t    res;
  logic [7:0] max_frame_len;

  rfcc_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .max_frame_len (max_frame_len)
  );

  // result slot is free if empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  rfcc_frame_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .rx_byte       (s1_byte_r),
    .frame_start   (s1_start_r),
    .max_frame_len (max_frame_len),
    .emit          (emit),
    .res           (res)
  );

  // input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_res_r.verdict;
  assign out_status_code  = out_res_r.status_code;
  assign out_frame_length = out_res_r.frame_length;
  assign out_crc_computed = out_res_r.crc_computed;

  // bad-length results carry no status and no CRC
  a_bad_len_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.verdict == VERDICT_BAD_LEN |->
      out_res_r.status_code == 8'h00 && out_res_r.crc_computed == 16'h0000)
    else $error("bad-length result with nonzero status or crc");

  // device error only on minimum-length frames
  a_dev_err_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.verdict == VERDICT_DEV_ERR |->
      out_res_r.frame_length == 8'(MIN_FRAME_LEN))
    else $error("device error verdict on frame longer than minimum");

  // judged frames respect the length limits
  a_judged_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.verdict != VERDICT_BAD_LEN |->
      out_res_r.frame_length >= 8'(MIN_FRAME_LEN) &&
      out_res_r.frame_length <= 8'(MAX_FRAME_LIMIT))
    else $error("judged frame length out of range");

  // input stalls only with a byte parked behind a blocked result
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

endmodule

### rtl/core/rfcc_cfg_regs.sv
// Configuration register bank: APB-style access to the maximum frame length.
module rfcc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rfcc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rfcc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rfcc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output logic [7:0]                       max_frame_len
);
  import rfcc_pkg::*;

  logic [7:0] max_len_r;
  logic [7:0] max_len_nxt;
  logic       wr_en;
  reg_idx_t   reg_idx;
  logic       addr_hit;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1]);
  assign addr_hit   = (reg_idx == REG_MAX_FRAME_LEN);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en && addr_hit) begin
      max_len_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (addr_hit) begin
      cfg_prdata = {{(CFG_DATA_W-8){1'b0}}, max_len_r};
    end
  end

  assign max_frame_len = max_len_r;

endmodule

### rtl/core/rfcc_frame_ctrl.sv
// Frame tracking state and verdict logic, one byte per fire.
module rfcc_frame_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic [7:0]          max_frame_len,
  output logic                emit,
  output rfcc_pkg::result_t   res
);
  import rfcc_pkg::*;

  logic        in_frame_r,  in_frame_nxt;
  logic [7:0]  pos_r,       pos_nxt;
  logic [7:0]  count_r,     count_nxt;
  logic [15:0] crc_r,       crc_nxt;
  logic [7:0]  status_r,    status_nxt;
  logic [7:0]  crc_lo_r,    crc_lo_nxt;

  logic [7:0]  body_end;
  logic        len_bad;
  logic [15:0] crc_expect;

  assign body_end   = count_r - 8'd2;
  assign len_bad    = (rx_byte < 8'(MIN_FRAME_LEN)) || (rx_byte > max_frame_len) ||
                      (rx_byte > 8'(MAX_FRAME_LIMIT));
  assign crc_expect = {rx_byte, crc_lo_r};

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    status_nxt   = status_r;
    crc_lo_nxt   = crc_lo_r;
    emit         = 1'b0;
    res          = '0;
    if (fire) begin
      if (frame_start) begin
        if (len_bad) begin
          in_frame_nxt     = 1'b0;
          pos_nxt          = '0;
          count_nxt        = '0;
          crc_nxt          = '0;
          status_nxt       = '0;
          crc_lo_nxt       = '0;
          emit             = 1'b1;
          res.verdict      = VERDICT_BAD_LEN;
          res.frame_length = rx_byte;
        end else begin
          in_frame_nxt = 1'b1;
          count_nxt    = rx_byte;
          pos_nxt      = 8'd1;
          crc_nxt      = crc_byte(16'h0000, rx_byte);
          status_nxt   = '0;
          crc_lo_nxt   = '0;
        end
      end else if (in_frame_r) begin
        if (pos_r < body_end) begin
          if (pos_r == 8'd1) begin
            status_nxt = rx_byte;
          end
          crc_nxt = crc_byte(crc_r, rx_byte);
          pos_nxt = pos_r + 8'd1;
        end else if (pos_r == body_end) begin
          crc_lo_nxt = rx_byte;
          pos_nxt    = pos_r + 8'd1;
        end else begin
          emit             = 1'b1;
          res.status_code  = status_r;
          res.frame_length = count_r;
          res.crc_computed = crc_r;
          if (crc_expect != crc_r) begin
            res.verdict = VERDICT_CRC_ERR;
          end else if (count_r == 8'(MIN_FRAME_LEN) && status_r != STATUS_OK) begin
            res.verdict = VERDICT_DEV_ERR;
          end else begin
            res.verdict = VERDICT_OK;
          end
          in_frame_nxt = 1'b0;
          pos_nxt      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      count_r    <= '0;
      crc_r      <= '0;
      status_r   <= '0;
      crc_lo_r   <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
      status_r   <= status_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

endmodule
